>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JSU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/jsu_pkg.sv
// Shared types, character codes and helper functions of the JSON string unescaper.
// No dependencies; used by every module of the block.
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_U         = 8'h75;

   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;
   localparam logic [7:0]  UTF8_MASK  = 8'h3F;
   localparam logic [15:0] UTF8_LIM1  = 16'h0080;
   localparam logic [15:0] UTF8_LIM2  = 16'h0800;

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_STR  = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX  = 3'd3,
      PH_DONE = 3'd4,
      PH_DROP = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      FAULT_NONE      = 3'd0,
      FAULT_END_WAIT  = 3'd1,
      FAULT_NOT_QUOTE = 3'd2,
      FAULT_END_ESC   = 3'd3,
      FAULT_BAD_HEX   = 3'd4,
      FAULT_END_STR   = 3'd5
   } fault_type;

   // One queue entry: all results caused by one accepted text byte.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] nbytes;
      logic       stat;
      logic       done;
      fault_type  fault;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

   // Bit 4 flags a hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] map_escape(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      case (c)
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0C;
         8'h6E:   r = 8'h0A;
         8'h72:   r = 8'h0D;
         8'h74:   r = 8'h09;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/jsu_front.sv
// Front end: accepts text bytes, runs the string phase machine and builds
// at most one queue entry per byte. Depends on jsu_pkg.
module jsu_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_text_byte,
   input  logic                       req_text_end,
   input  jsu_pkg::queue_status_type  q_status,
   output logic                       push,
   output jsu_pkg::cmd_type           cmd
);

   jsu_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [1:0]         hex_count_ff, hex_count_in;
   logic [15:0]        code_point_ff, code_point_in;
   logic [4:0]         hexv;
   logic [15:0]        cp_new;
   logic               accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign hexv      = jsu_pkg::hex_value(req_text_byte);
   assign cp_new    = {code_point_ff[11:0], hexv[3:0]};

   // Next state
   always_comb begin
      phase_mid     = phase_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      unique case (phase_ff)
         jsu_pkg::PH_STR: begin
            if (req_text_byte == jsu_pkg::CHAR_QUOTE) begin
               phase_mid = jsu_pkg::PH_DONE;
            end else if (req_text_byte == jsu_pkg::CHAR_BACKSLASH) begin
               phase_mid = jsu_pkg::PH_ESC;
            end
         end
         jsu_pkg::PH_ESC: begin
            if (req_text_byte == jsu_pkg::CHAR_U) begin
               phase_mid     = jsu_pkg::PH_HEX;
               hex_count_in  = 2'd0;
               code_point_in = 16'd0;
            end else begin
               phase_mid = jsu_pkg::PH_STR;
            end
         end
         jsu_pkg::PH_HEX: begin
            if (!hexv[4]) begin
               phase_mid = jsu_pkg::PH_DROP;
            end else begin
               code_point_in = cp_new;
               if (hex_count_ff == 2'd3) begin
                  hex_count_in = 2'd0;
                  phase_mid    = jsu_pkg::PH_STR;
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
               end
            end
         end
         jsu_pkg::PH_DONE, jsu_pkg::PH_DROP: begin
            phase_mid = phase_ff;
         end
         default: begin
            if (req_text_byte == jsu_pkg::CHAR_QUOTE) begin
               phase_mid = jsu_pkg::PH_STR;
            end else if (req_text_byte == jsu_pkg::CHAR_SPACE ||
                         req_text_byte == jsu_pkg::CHAR_TAB   ||
                         req_text_byte == jsu_pkg::CHAR_CR    ||
                         req_text_byte == jsu_pkg::CHAR_LF) begin
               phase_mid = jsu_pkg::PH_WAIT;
            end else begin
               phase_mid = jsu_pkg::PH_DROP;
            end
         end
      endcase
      phase_in = phase_mid;
      // Final byte of the text: rearm for the next text
      if (req_text_end) begin
         phase_in      = jsu_pkg::PH_WAIT;
         hex_count_in  = 2'd0;
         code_point_in = 16'd0;
      end
   end

   // Queue entry
   always_comb begin
      cmd = '0;
      unique case (phase_ff)
         jsu_pkg::PH_STR: begin
            if (req_text_byte == jsu_pkg::CHAR_QUOTE) begin
               cmd.stat = 1'b1;
               cmd.done = 1'b1;
            end else if (req_text_byte != jsu_pkg::CHAR_BACKSLASH) begin
               cmd.byte0  = req_text_byte;
               cmd.nbytes = 2'd1;
            end
         end
         jsu_pkg::PH_ESC: begin
            if (req_text_byte != jsu_pkg::CHAR_U) begin
               cmd.byte0  = jsu_pkg::map_escape(req_text_byte);
               cmd.nbytes = 2'd1;
            end
         end
         jsu_pkg::PH_HEX: begin
            if (!hexv[4]) begin
               cmd.stat  = 1'b1;
               cmd.fault = jsu_pkg::FAULT_BAD_HEX;
            end else if (hex_count_ff == 2'd3) begin
               if (cp_new < jsu_pkg::UTF8_LIM1) begin
                  cmd.byte0  = cp_new[7:0];
                  cmd.nbytes = 2'd1;
               end else if (cp_new < jsu_pkg::UTF8_LIM2) begin
                  cmd.byte0  = jsu_pkg::UTF8_LEAD2 | {3'd0, cp_new[10:6]};
                  cmd.byte1  = jsu_pkg::UTF8_CONT | (cp_new[7:0] & jsu_pkg::UTF8_MASK);
                  cmd.nbytes = 2'd2;
               end else begin
                  cmd.byte0  = jsu_pkg::UTF8_LEAD3 | {4'd0, cp_new[15:12]};
                  cmd.byte1  = jsu_pkg::UTF8_CONT | (cp_new[13:6] & jsu_pkg::UTF8_MASK);
                  cmd.byte2  = jsu_pkg::UTF8_CONT | (cp_new[7:0] & jsu_pkg::UTF8_MASK);
                  cmd.nbytes = 2'd3;
               end
            end
         end
         jsu_pkg::PH_DONE, jsu_pkg::PH_DROP: begin
            cmd.stat = 1'b0;
         end
         default: begin
            if (phase_mid == jsu_pkg::PH_DROP) begin
               cmd.stat  = 1'b1;
               cmd.fault = jsu_pkg::FAULT_NOT_QUOTE;
            end
         end
      endcase
      // Text ends while waiting for or inside the string: append the status result
      if (req_text_end) begin
         case (phase_mid)
            jsu_pkg::PH_WAIT: begin
               cmd.stat  = 1'b1;
               cmd.fault = jsu_pkg::FAULT_END_WAIT;
            end
            jsu_pkg::PH_STR: begin
               cmd.stat  = 1'b1;
               cmd.fault = jsu_pkg::FAULT_END_STR;
            end
            jsu_pkg::PH_ESC: begin
               cmd.stat  = 1'b1;
               cmd.fault = jsu_pkg::FAULT_END_ESC;
            end
            jsu_pkg::PH_HEX: begin
               cmd.stat  = 1'b1;
               cmd.fault = jsu_pkg::FAULT_BAD_HEX;
            end
            default: begin
               cmd.stat = cmd.stat;
            end
         endcase
      end
   end

   // Bytes that cause no result never enter the queue
   assign push = accept && (cmd.nbytes != 2'd0 || cmd.stat);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= jsu_pkg::PH_WAIT;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 16'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hex_count_ff  <= hex_count_in;
         code_point_ff <= code_point_in;
      end
   end

endmodule

>>> rtl/jsu_queue.sv
// Short queue of result groups between front and back end.
// Depends on jsu_pkg for the entry type.
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  jsu_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output jsu_pkg::cmd_type           head_cmd,
   output jsu_pkg::queue_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::cmd_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign do_pop            = pop && (count_ff != '0);
   assign head_cmd          = entry_ff[rd_ptr_ff];
   assign status.full       = (count_ff == CNT_W'(DEPTH));
   assign status.head_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/jsu_back.sv
// Back end: walks the head queue entry one result a beat into the output register.
// Depends on jsu_pkg.
module jsu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  jsu_pkg::cmd_type           head_cmd,
   input  jsu_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_decoded_byte,
   output logic                       rsp_is_data,
   output logic                       rsp_string_done,
   output logic [2:0]                 rsp_fault,
   output logic                       rsp_run_last
);

   logic       valid_ff, valid_in;
   logic [1:0] sub_ff, sub_in;
   logic [7:0] byte_ff, byte_in;
   logic       data_ff, data_in;
   logic       done_ff, done_in;
   logic [2:0] fault_ff, fault_in;
   logic       last_ff, last_in;
   logic       load;
   logic [2:0] total;
   logic       is_last;

   assign load    = !valid_ff || rsp_ready;
   assign total   = {1'b0, head_cmd.nbytes} + {2'b0, head_cmd.stat};
   assign is_last = ({1'b0, sub_ff} + 3'd1) == total;
   assign pop     = load && q_status.head_valid && is_last;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      byte_in  = byte_ff;
      data_in  = data_ff;
      done_in  = done_ff;
      fault_in = fault_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = q_status.head_valid;
         if (q_status.head_valid) begin
            last_in = is_last;
            sub_in  = is_last ? 2'd0 : sub_ff + 2'd1;
            if (sub_ff < head_cmd.nbytes) begin
               data_in  = 1'b1;
               done_in  = 1'b0;
               fault_in = jsu_pkg::FAULT_NONE;
               case (sub_ff)
                  2'd0:    byte_in = head_cmd.byte0;
                  2'd1:    byte_in = head_cmd.byte1;
                  default: byte_in = head_cmd.byte2;
               endcase
            end else begin
               data_in  = 1'b0;
               byte_in  = 8'd0;
               done_in  = head_cmd.done;
               fault_in = head_cmd.fault;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      data_ff  <= data_in;
      done_ff  <= done_in;
      fault_ff <= fault_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_decoded_byte = byte_ff;
   assign rsp_is_data      = data_ff;
   assign rsp_string_done  = done_ff;
   assign rsp_fault        = fault_ff;
   assign rsp_run_last     = last_ff;

endmodule

>>> rtl/json_string_unescape.sv
// JSON string unescaper: accepts one text byte per cycle while the queue has room.
// A byte's results are queued, then moved from the queue head to the rsp register.
// Throughput: one result per cycle from the back end while rsp_ready holds; a byte
// yields 0 to 4 results, one for each UTF-8 byte it emits plus any status result.
// Reset: synchronous, clears the phase machine, queue count and output valid flag.
module json_string_unescape #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_text_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_decoded_byte,
   output logic       rsp_is_data,
   output logic       rsp_string_done,
   output logic [2:0] rsp_fault,
   output logic       rsp_run_last
);

   jsu_pkg::cmd_type           push_cmd, head_cmd;
   jsu_pkg::queue_status_type  q_status;
   logic                       push, pop;

   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_text_end  (req_text_end),
      .q_status      (q_status),
      .push          (push),
      .cmd           (push_cmd)
   );

   jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   jsu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_string_done  (rsp_string_done),
      .rsp_fault        (rsp_fault),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

>>> rtl/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on assert_macros.svh and jsu_pkg.
`include "assert_macros.svh"

module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_decoded_byte,
   input logic       rsp_is_data,
   input logic       rsp_string_done,
   input logic [2:0] rsp_fault,
   input logic       rsp_run_last
);

   // Hold a stalled result beat
   `JSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Data beats carry no status
   `JSU_ASSERT_NOW(a_data_clean, clock, reset, rsp_valid && rsp_is_data,
                   !rsp_string_done && rsp_fault == jsu_pkg::FAULT_NONE)

   // Status beats carry a zero byte
   `JSU_ASSERT_NOW(a_stat_zero, clock, reset, rsp_valid && !rsp_is_data, rsp_decoded_byte == 8'd0)

   // A fault or the closing quote is always the last beat of its byte
   `JSU_ASSERT_NOW(a_stat_last, clock, reset,
                   rsp_valid && (rsp_string_done || rsp_fault != jsu_pkg::FAULT_NONE),
                   rsp_run_last)

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for json_string_unescape: random and directed text streams,
// expected beats from a behavioral decoder. Depends on jsu_pkg and the block's RTL.
module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 250;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } text_beat_type;

   typedef struct {
      logic [7:0]         decoded;
      logic               data;
      logic               done;
      jsu_pkg::fault_type flt;
      logic               last;
   } decoded_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_text_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_decoded_byte;
   logic       rsp_is_data;
   logic       rsp_string_done;
   logic [2:0] rsp_fault;
   logic       rsp_run_last;

   text_beat_type    pending_text[$];
   decoded_beat_type expected_out[$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   int  mismatches = 0;
   bit  req_taken = 1'b0;

   // decoder state mirrored by the predictor
   jsu_pkg::phase_type dec_phase = jsu_pkg::PH_WAIT;
   logic [1:0]         dec_hex_cnt = 2'd0;
   logic [15:0]        dec_code = 16'h0000;

   json_string_unescape i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_text_end     (req_text_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_string_done  (rsp_string_done),
      .rsp_fault        (rsp_fault),
      .rsp_run_last     (rsp_run_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Bit 4 set when c is a hex digit; bits 3:0 carry its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
      if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   function automatic logic [7:0] escape_char(input logic [7:0] c);
      case (c)
         "b":     return 8'h08;
         "f":     return 8'h0C;
         "n":     return jsu_pkg::CHAR_LF;
         "r":     return jsu_pkg::CHAR_CR;
         "t":     return jsu_pkg::CHAR_TAB;
         default: return c;
      endcase
   endfunction

   function automatic decoded_beat_type data_beat(input logic [7:0] b);
      return '{b, 1'b1, 1'b0, jsu_pkg::FAULT_NONE, 1'b0};
   endfunction

   function automatic decoded_beat_type status_beat(input logic done,
                                                    input jsu_pkg::fault_type f);
      return '{8'h00, 1'b0, done, f, 1'b0};
   endfunction

   // Work out every beat one accepted text byte causes and append them.
   task automatic decode_text_byte(input logic [7:0] c, input logic end_flag);
      decoded_beat_type beats[$];
      logic [4:0]       nib;
      logic [15:0]      cp;
      case (dec_phase)
         jsu_pkg::PH_STR: begin
            if (c == jsu_pkg::CHAR_QUOTE) begin
               beats.insert(beats.size(), status_beat(1'b1, jsu_pkg::FAULT_NONE));
               dec_phase = jsu_pkg::PH_DONE;
            end else if (c == jsu_pkg::CHAR_BACKSLASH) begin
               dec_phase = jsu_pkg::PH_ESC;
            end else begin
               beats.insert(beats.size(), data_beat(c));
            end
         end
         jsu_pkg::PH_ESC: begin
            if (c == jsu_pkg::CHAR_U) begin
               dec_phase = jsu_pkg::PH_HEX;
               dec_hex_cnt = 2'd0;
               dec_code = 16'h0000;
            end else begin
               beats.insert(beats.size(), data_beat(escape_char(c)));
               dec_phase = jsu_pkg::PH_STR;
            end
         end
         jsu_pkg::PH_HEX: begin
            nib = hex_nibble(c);
            if (!nib[4]) begin
               beats.insert(beats.size(), status_beat(1'b0, jsu_pkg::FAULT_BAD_HEX));
               dec_phase = jsu_pkg::PH_DROP;
            end else begin
               cp = {dec_code[11:0], nib[3:0]};
               dec_code = cp;
               if (dec_hex_cnt == 2'd3) begin
                  dec_hex_cnt = 2'd0;
                  dec_phase = jsu_pkg::PH_STR;
                  if (cp < jsu_pkg::UTF8_LIM1) begin
                     beats.insert(beats.size(), data_beat(cp[7:0]));
                  end else if (cp < jsu_pkg::UTF8_LIM2) begin
                     beats.insert(beats.size(),
                                  data_beat(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]}));
                     beats.insert(beats.size(),
                                  data_beat(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}));
                  end else begin
                     beats.insert(beats.size(),
                                  data_beat(jsu_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]}));
                     beats.insert(beats.size(),
                                  data_beat(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]}));
                     beats.insert(beats.size(),
                                  data_beat(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}));
                  end
               end else begin
                  dec_hex_cnt = dec_hex_cnt + 2'd1;
               end
            end
         end
         jsu_pkg::PH_DONE, jsu_pkg::PH_DROP: ;
         default: begin
            if (c == jsu_pkg::CHAR_QUOTE) begin
               dec_phase = jsu_pkg::PH_STR;
            end else if (c inside {jsu_pkg::CHAR_SPACE, jsu_pkg::CHAR_TAB,
                                   jsu_pkg::CHAR_CR, jsu_pkg::CHAR_LF}) begin
               dec_phase = jsu_pkg::PH_WAIT;
            end else begin
               beats.insert(beats.size(), status_beat(1'b0, jsu_pkg::FAULT_NOT_QUOTE));
               dec_phase = jsu_pkg::PH_DROP;
            end
         end
      endcase
      if (end_flag) begin
         case (dec_phase)
            jsu_pkg::PH_WAIT:
               beats.insert(beats.size(), status_beat(1'b0, jsu_pkg::FAULT_END_WAIT));
            jsu_pkg::PH_STR:
               beats.insert(beats.size(), status_beat(1'b0, jsu_pkg::FAULT_END_STR));
            jsu_pkg::PH_ESC:
               beats.insert(beats.size(), status_beat(1'b0, jsu_pkg::FAULT_END_ESC));
            jsu_pkg::PH_HEX:
               beats.insert(beats.size(), status_beat(1'b0, jsu_pkg::FAULT_BAD_HEX));
            default: ;
         endcase
         dec_phase = jsu_pkg::PH_WAIT;
         dec_hex_cnt = 2'd0;
         dec_code = 16'h0000;
      end
      if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
      foreach (beats[i]) expected_out.insert(expected_out.size(), beats[i]);
   endtask

   // Sample both channels, predict on accepted text beats, check result beats.
   always @(posedge clock) begin
      decoded_beat_type want;
      if (reset) begin
         req_taken = 1'b0;
         dec_phase = jsu_pkg::PH_WAIT;
         dec_hex_cnt = 2'd0;
         dec_code = 16'h0000;
      end else begin
         req_taken = req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat byte %02h data %0b done %0b fault %0d last %0b",
                        $time, rsp_decoded_byte, rsp_is_data, rsp_string_done, rsp_fault,
                        rsp_run_last);
            end else begin
               want = expected_out.pop_front();
               if (rsp_decoded_byte !== want.decoded || rsp_is_data !== want.data ||
                   rsp_string_done !== want.done || rsp_fault !== want.flt ||
                   rsp_run_last !== want.last) begin
                  mismatches++;
                  $display("%0t: mismatch expected byte %02h data %0b done %0b fault %0d last %0b",
                           $time, want.decoded, want.data, want.done, want.flt, want.last);
                  $display("%0t:          actual   byte %02h data %0b done %0b fault %0d last %0b",
                           $time, rsp_decoded_byte, rsp_is_data, rsp_string_done, rsp_fault,
                           rsp_run_last);
               end
            end
         end
         if (req_taken) decode_text_byte(req_text_byte, req_text_end);
      end
   end

   // Text driver: advance only after the current beat is taken.
   always @(negedge clock) begin
      text_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_text.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_text.pop_front();
            req_valid <= 1'b1;
            req_text_byte <= nxt.text;
            req_text_end <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus a long hold on request.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return 8'h30 + nib;
      return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0:       return jsu_pkg::CHAR_SPACE;
         1:       return jsu_pkg::CHAR_TAB;
         2:       return jsu_pkg::CHAR_CR;
         default: return jsu_pkg::CHAR_LF;
      endcase
   endfunction

   task automatic queue_literal(input string s);
      for (int i = 0; i < s.len(); i++) begin
         pending_text.insert(pending_text.size(), '{s[i], i == s.len() - 1});
      end
   endtask

   // Queue one random text: mostly well-formed strings, some noise, cut or corrupted.
   task automatic queue_text(output int n);
      logic [7:0]  txt[$];
      logic [7:0]  b;
      logic [4:0]  nib;
      logic [15:0] cp;
      logic [15:0] corners[6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
      string       esc_letters = "\"\\/bfnrt";
      int          roll;
      int          pos;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         repeat ($urandom_range(1, 4)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) txt.insert(txt.size(), pick_blank());
         txt.insert(txt.size(), jsu_pkg::CHAR_QUOTE);
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  do b = 8'($urandom_range(0, 255));
                  while (b == jsu_pkg::CHAR_QUOTE || b == jsu_pkg::CHAR_BACKSLASH);
                  txt.insert(txt.size(), b);
               end
               4, 5, 6: begin
                  txt.insert(txt.size(), jsu_pkg::CHAR_BACKSLASH);
                  if ($urandom_range(0, 4) == 0) begin
                     do b = 8'($urandom_range(0, 255));
                     while (b == jsu_pkg::CHAR_U);
                     txt.insert(txt.size(), b);
                  end else begin
                     txt.insert(txt.size(),
                                esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
                  end
               end
               default: begin
                  txt.insert(txt.size(), jsu_pkg::CHAR_BACKSLASH);
                  txt.insert(txt.size(), jsu_pkg::CHAR_U);
                  case ($urandom_range(0, 3))
                     0:       cp = 16'($urandom_range(0, 16'h7F));
                     1:       cp = 16'($urandom_range(16'h80, 16'h7FF));
                     2:       cp = 16'($urandom_range(16'h800, 16'hFFFF));
                     default: cp = corners[$urandom_range(0, 5)];
                  endcase
                  for (int k = 3; k >= 0; k--) begin
                     txt.insert(txt.size(), hex_char(cp[4*k +: 4], 1'($urandom_range(0, 1))));
                  end
                  // plant a bad digit now and then
                  if ($urandom_range(0, 11) == 0) begin
                     do begin
                        b = 8'($urandom_range(0, 255));
                        nib = hex_nibble(b);
                     end while (nib[4]);
                     txt[txt.size() - 1 - $urandom_range(0, 3)] = b;
                  end
               end
            endcase
         end
         txt.insert(txt.size(), jsu_pkg::CHAR_QUOTE);
         repeat ($urandom_range(0, 2)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
         if (roll >= 80 && roll < 92) begin
            pos = $urandom_range(1, txt.size());
            while (txt.size() > pos) void'(txt.pop_back());
         end else if (roll >= 92) begin
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end
      foreach (txt[i]) pending_text.insert(pending_text.size(), '{txt[i], i == txt.size() - 1});
      n = txt.size();
   endtask

   task automatic queue_random(input int target);
      int sent;
      int n;
      sent = 0;
      while (sent < target) begin
         queue_text(n);
         sent += n;
      end
   endtask

   // Wait until every text beat is taken and every expected beat has arrived.
   task automatic drain();
      while (pending_text.size() != 0 || req_valid) @(posedge clock);
      @(negedge clock);
      while (expected_out.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // quote as final byte, stray byte, blank as final byte
      queue_literal("\"");
      queue_literal("x");
      queue_literal(" ");
      // escapes with two- and three-byte code points, closing quote as final byte
      queue_literal("\t\"\\n\\u00e9\\u20AC\"");
      // text ends after a backslash, and inside a hex escape
      queue_literal("\"\\");
      queue_literal("\"\\u1");
      drain();

      set_idling(0, 0);
      queue_random(90);
      drain();
      set_idling(58, 0);
      queue_random(90);
      drain();
      set_idling(0, 58);
      queue_random(90);
      drain();
      set_idling(17, 17);
      queue_random(70);
      drain();

      // hold the result side off while text keeps coming, so the input backs up
      set_idling(0, 0);
      hold_requests++;
      queue_random(40);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
